>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the decimal text converter.
// Expects clk and rst in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never hold at a rising edge of clk outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/core/s2a_pkg.sv
// Shared types and constants of the signed binary to decimal ASCII converter.
// No dependencies.
package s2a_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int NUM_DIGITS = 10;
  localparam int STEP_BITS  = 3;
  // Shift steps needed to push all magnitude bits through the digit row.
  localparam int STEPS      = (VALUE_W + STEP_BITS - 1) / STEP_BITS;
  localparam int SREG_W     = STEPS * STEP_BITS;
  // One slot for the sign, then one slot for each digit.
  localparam int EMIT_SLOTS = NUM_DIGITS + 1;
  localparam int CNT_W      = $clog2(STEPS + 1);
  localparam int SLOT_W     = $clog2(EMIT_SLOTS + 1);

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic load;
    logic neg;
  } xfer_t;

endpackage

>>> rtl/core/s2a_dd_cell.sv
// One BCD digit cell of the shift-and-add-3 row.
// Depends on s2a_pkg.
module s2a_dd_cell import s2a_pkg::*; (
  input  logic                 clk,
  input  logic                 clr,
  input  logic                 en,
  input  logic [STEP_BITS-1:0] din,
  output logic [STEP_BITS-1:0] dout,
  output digit_t               digit
);

  digit_t digit_next;

  // Each step corrects a digit of five or more, hands its top bit to the
  // next cell and shifts in the bit from the cell below; bit 0 of din is
  // the first step.
  always_comb begin
    digit_t v;
    v = digit;
    for (int s = 0; s < STEP_BITS; s++) begin
      if (v >= 4'd5) begin
        v = v + 4'd3;
      end
      dout[s] = v[3];
      v = {v[2:0], din[s]};
    end
    digit_next = v;
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      digit <= '0;
    end else if (en) begin
      digit <= digit_next;
    end
  end

endmodule

>>> rtl/core/s2a_emit.sv
// Character serializer: shifts the finished digits out most significant
// first, with the sign ahead and leading zeros suppressed. Depends on s2a_pkg.
module s2a_emit import s2a_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  xfer_t             xfer,
  input  digit_t            digits [NUM_DIGITS],
  output logic              ready,
  output logic              strobe,
  output logic [CHAR_W-1:0] char_code,
  output logic              last_char
);

  logic [SLOT_W-1:0] slot;
  digit_t            dig [NUM_DIGITS];
  logic              neg;
  logic              seen;

  logic   active;
  logic   sign_slot;
  logic   final_slot;
  digit_t top;
  logic   show;

  assign active     = slot != '0;
  assign sign_slot  = slot == SLOT_W'(EMIT_SLOTS);
  assign final_slot = slot == SLOT_W'(1);
  assign top        = dig[NUM_DIGITS-1];
  // The ones digit always shows, so zero still gives one character.
  assign show       = seen | (top != '0) | final_slot;
  // A new item may load during the final slot of the current one.
  assign ready      = slot <= SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot   <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= active & (sign_slot ? neg : show);
      if (xfer.load) begin
        slot <= SLOT_W'(EMIT_SLOTS);
      end else if (active) begin
        slot <= slot - SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (sign_slot) begin
        char_code <= CH_MINUS;
        last_char <= 1'b0;
      end else begin
        char_code <= CH_ZERO + {{(CHAR_W-4){1'b0}}, top};
        last_char <= final_slot;
      end
    end
    if (xfer.load) begin
      dig  <= digits;
      neg  <= xfer.neg;
      seen <= 1'b0;
    end else if (active && !sign_slot) begin
      seen <= seen | (top != '0);
      for (int i = NUM_DIGITS - 1; i > 0; i--) begin
        dig[i] <= dig[i-1];
      end
      dig[0] <= '0;
    end
  end

endmodule

>>> rtl/core/signed_binary_to_decimal_ascii.sv
// Signed 32-bit integer to decimal ASCII text, one character per strobe.
// Each number passes through 11 steps of three bits each in the BCD digit
// row, then is handed over to the character serializer. A new number is
// accepted once the row is free, even while the previous text still goes out.
// Characters leave at up to one per cycle; the receiver cannot stall them.
// Synchronous reset clears the step counter, handover flag, slot counter, strobe.
`include "assert_macros.svh"

module signed_binary_to_decimal_ascii import s2a_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [VALUE_W-1:0] value,
  output logic                      strobe,
  output logic [CHAR_W-1:0]         char_code,
  output logic                      last_char
);

  logic [CNT_W-1:0]   conv_cnt;
  logic               full;
  logic               neg_hold;
  logic [SREG_W-1:0]  sreg;

  logic               running;
  logic               accept;
  logic               emit_ready;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag;
  xfer_t              xfer;

  logic [STEP_BITS-1:0] link [NUM_DIGITS];
  logic [STEP_BITS-1:0] top_carry;
  digit_t               digits [NUM_DIGITS];

  assign running   = conv_cnt != '0;
  assign xfer.load = full & emit_ready;
  assign xfer.neg  = neg_hold;
  assign busy      = running | (full & ~emit_ready);
  assign accept    = start & ~busy;

  // Unsigned magnitude, so the most negative value converts as well.
  assign raw = VALUE_W'(value);
  assign mag = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      conv_cnt <= '0;
      full     <= 1'b0;
    end else begin
      if (accept) begin
        conv_cnt <= CNT_W'(STEPS);
      end else if (running) begin
        conv_cnt <= conv_cnt - CNT_W'(1);
      end
      if (conv_cnt == CNT_W'(1)) begin
        full <= 1'b1;
      end else if (xfer.load) begin
        full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sreg     <= {{(SREG_W-VALUE_W){1'b0}}, mag};
      neg_hold <= raw[VALUE_W-1];
    end else if (running) begin
      sreg <= {sreg[SREG_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
    end
  end

  // The top bits of the shift register enter the ones cell, first step first.
  for (genvar j = 0; j < STEP_BITS; j++) begin : g_feed
    assign link[0][j] = sreg[SREG_W-1-j];
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [STEP_BITS-1:0] carry;

    s2a_dd_cell u_cell (
      .clk   (clk),
      .clr   (accept),
      .en    (running),
      .din   (link[i]),
      .dout  (carry),
      .digit (digits[i])
    );

    if (i < NUM_DIGITS - 1) begin : g_link
      assign link[i+1] = carry;
    end else begin : g_top
      assign top_carry = carry;
    end
  end

  s2a_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .xfer      (xfer),
    .digits    (digits),
    .ready     (emit_ready),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

  `ASSERT_CLK(a_busy_after_accept, (start && !busy) |=> busy, "accepted item did not raise busy")
  `ASSERT_CLK(a_no_overflow, running |-> (top_carry == '0), "digit row overflowed")
  `ASSERT_NEVER(a_run_and_full, running && full, "conversion running over a held result")
  `ASSERT_CLK(a_minus_not_last, (strobe && char_code == CH_MINUS) |-> !last_char,
    "minus sign flagged as last character")

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for signed_binary_to_decimal_ascii.
// Depends on s2a_pkg and the converter RTL; drives numbers and checks each
// character against a predictor of the decimal text.
`timescale 1ns / 1ps

module tb_top;
  import s2a_pkg::*;

  localparam int RADIX       = 10;
  localparam int IDLE_FREE   = 40;    // Items at the tail sent with no idling.
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] value;
  logic                      strobe;
  logic [CHAR_W-1:0]         char_code;
  logic                      last_char;

  logic [VALUE_W-1:0] numbers_pending[$];
  bit                 drain_first[$];
  text_char_t         expected_chars[$];

  int        errors;
  int        numbers_sent;
  int        negatives_sent;
  int        chars_checked;
  int        gap_left;
  int        stall_count;
  bit [11:0] lengths_seen;

  signed_binary_to_decimal_ascii DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Expected characters of one number: optional sign, then digits, most
  // significant first. The magnitude of the most negative value fits in
  // 32 unsigned bits, so the negation is exact.
  function automatic void predict_text(input logic [VALUE_W-1:0] raw);
    logic               neg;
    logic [VALUE_W-1:0] mag;
    digit_t             digs[$];
    text_char_t         c;
    neg = raw[VALUE_W-1];
    mag = neg ? (~raw + 1'b1) : raw;
    do begin
      digs.push_front(digit_t'(mag % RADIX));
      mag = mag / RADIX;
    end while (mag != 0);
    if (neg) begin
      c.code = CH_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
      negatives_sent++;
    end
    foreach (digs[i]) begin
      c.code = CH_ZERO + CHAR_W'(digs[i]);
      c.last = (i == digs.size() - 1);
      expected_chars.push_back(c);
    end
    lengths_seen[digs.size() + neg] = 1'b1;
  endfunction

  // Random number with a random digit count, so every text length shows up.
  function automatic logic [VALUE_W-1:0] random_number();
    int          ndig;
    longint      lo;
    longint      hi;
    longint      mag;
    ndig = $urandom_range(10, 1);
    lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
    hi = 64'd10 ** ndig - 1;
    if (hi > 64'd2147483648) hi = 64'd2147483648;
    mag = lo + longint'($urandom_range(int'(hi - lo), 0));
    if ($urandom_range(1, 0) == 1) return VALUE_W'(-mag);
    if (mag > 64'd2147483647) mag = 64'd2147483647;
    return VALUE_W'(mag);
  endfunction

  // Driver: an item moves when start is high and busy is low at the edge.
  always @(posedge clk) begin : drive_numbers
    bit taken;
    taken = start && !busy;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (taken) begin
        predict_text(value);
        numbers_sent++;
      end
      if (start && !taken) begin
        // Hold the item until the converter takes it.
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        value    <= $urandom();
        gap_left <= gap_left - 1;
      end else if (numbers_pending.size() == 0) begin
        start <= 1'b0;
      end else if (drain_first[0] && expected_chars.size() != 0) begin
        start <= 1'b0;
      end else if (numbers_pending.size() > IDLE_FREE && $urandom_range(3, 0) == 0) begin
        start    <= 1'b0;
        value    <= $urandom();
        gap_left <= $urandom_range(3, 0);
      end else begin
        start <= 1'b1;
        value <= numbers_pending.pop_front();
        void'(drain_first.pop_front());
      end
    end
  end

  // Monitor: every strobe carries one character that must match in order.
  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected character %0d last=%0b", char_code, last_char));
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (char_code !== want.code)
          report_mismatch($sformatf("char_code %0d, expected %0d", char_code, want.code));
        if (last_char !== want.last)
          report_mismatch($sformatf("last_char %0b, expected %0b", last_char, want.last));
      end
    end
  end

  // Watchdog on cycles where neither an item nor a character moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      stall_count <= 0;
    end else if (stall_count == STALL_LIMIT - 1) begin
      $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("tb_top failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  initial begin
    logic [VALUE_W-1:0] directed[$];
    errors         = 0;
    numbers_sent   = 0;
    negatives_sent = 0;
    chars_checked  = 0;
    lengths_seen   = '0;
    stall_count    = 0;
    gap_left       = 0;
    rst   = 1'b1;
    start = 1'b0;
    value = '0;

    // Zero, all ones, single digits, powers of ten, the extremes and the
    // most negative value, plus alternating bit patterns.
    directed = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'd999999999, 32'd1000000000, -32'sd999999999, -32'sd1000000000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd123456789,
                 32'h5555_5555, 32'hAAAA_AAAA, -32'sd5};
    foreach (directed[i]) begin
      numbers_pending.push_back(directed[i]);
      drain_first.push_back(i == 4);
    end
    for (int i = 0; i < 182; i++) begin
      numbers_pending.push_back(random_number());
      drain_first.push_back(i == 0 || i == 90);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (numbers_pending.size() != 0 || start || expected_chars.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);
    while (expected_chars.size() != 0) begin
      report_mismatch($sformatf("character %0d never arrived", expected_chars[0].code));
      void'(expected_chars.pop_front());
    end

    $display("Converted %0d numbers (%0d negative) into %0d checked characters.",
             numbers_sent, negatives_sent, chars_checked);
    $display("Text lengths seen (bit n = n characters): %b", lengths_seen);
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
